[hw/rtl/lpg_pkg.sv]
// Shared types, register indexes and arithmetic helpers for the LED pixel encoder.
package lpg_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned TICK_W          = 15;
    localparam int unsigned COMP_W          = 8;
    localparam int unsigned CFG_W           = 15;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned WORD_W          = 32;   // up to four bytes per pixel
    localparam int unsigned SYM_IDX_W       = 6;    // symbol index 0..32 within a pixel

    localparam logic [COMP_W-1:0] FULL_SCALE = 8'hFF;

    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd3;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 15'd9;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 15'd9;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 15'd3;
    localparam logic [TICK_W-1:0] LATCH_RST     = 15'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS  = 3'd0,
        REG_COLOR_ORDER = 3'd1,
        REG_HAS_WHITE   = 3'd2,
        REG_ZERO_HIGH   = 3'd3,
        REG_ZERO_LOW    = 3'd4,
        REG_ONE_HIGH    = 3'd5,
        REG_ONE_LOW     = 3'd6,
        REG_LATCH_TICKS = 3'd7
    } lpg_reg_idx_t;

    typedef enum logic [2:0] {
        ORD_RGB = 3'd0,
        ORD_RBG = 3'd1,
        ORD_GRB = 3'd2,
        ORD_GBR = 3'd3,
        ORD_BRG = 3'd4,
        ORD_BGR = 3'd5
    } lpg_order_t;

    typedef struct packed {
        logic [COMP_W-1:0] brightness;
        logic [2:0]        color_order;
        logic              has_white;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch_ticks;
    } lpg_cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;   // first byte on the line in the top bits
        logic              last;
    } lpg_entry_t;

    // floor(x/255) for x <= 255*255: one add and one compare.
    function automatic logic [COMP_W-1:0] div255(input logic [2*COMP_W-1:0] x);
        logic [COMP_W-1:0] q0;
        logic [COMP_W:0]   r;
        q0 = x[2*COMP_W-1:COMP_W];
        r  = {1'b0, x[COMP_W-1:0]} + {1'b0, q0};
        return (r >= {1'b0, FULL_SCALE}) ? q0 + 8'd1 : q0;
    endfunction

    // Component index (0 red, 1 green, 2 blue) sent at byte position pos.
    function automatic logic [1:0] order_sel(input logic [2:0] ord, input logic [1:0] pos);
        logic [5:0] tri_sel;   // {pos0, pos1, pos2}
        case (ord)
            ORD_RGB: tri_sel = {2'd0, 2'd1, 2'd2};
            ORD_RBG: tri_sel = {2'd0, 2'd2, 2'd1};
            ORD_GRB: tri_sel = {2'd1, 2'd0, 2'd2};
            ORD_GBR: tri_sel = {2'd1, 2'd2, 2'd0};
            ORD_BRG: tri_sel = {2'd2, 2'd0, 2'd1};
            default: tri_sel = {2'd2, 2'd1, 2'd0};
        endcase
        case (pos)
            2'd0:    return tri_sel[5:4];
            2'd1:    return tri_sel[3:2];
            default: return tri_sel[1:0];
        endcase
    endfunction

endpackage

[hw/rtl/lpg_front.sv]
// Front pipeline: gamma square, brightness scale, color ordering into queue words.
module lpg_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lpg_pkg::lpg_cfg_t         cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [lpg_pkg::COMP_W-1:0] in_comp [4],
    input  logic                      in_last,
    output logic                      push,
    input  logic                      q_full,
    output lpg_pkg::lpg_entry_t       push_entry
);

    localparam int unsigned CW = lpg_pkg::COMP_W;
    localparam int unsigned PW = 2 * CW;

    logic          v1_reg, v2_reg;
    logic          last1_reg, last2_reg;
    logic [2*CW-1:0] sq_reg   [4];
    logic [2*CW-1:0] prod_reg [4];
    logic          en1, en2;
    logic [CW-1:0] comp [4];

    assign en2      = !v2_reg || !q_full;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign push     = v2_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    // stage 1: v*v
    always_ff @(posedge aclk) begin
        if (en1) begin
            last1_reg <= in_last;
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= PW'(in_comp[i]) * PW'(in_comp[i]);
            end
        end
    end

    // stage 2: gamma = v*v/255, then times brightness
    always_ff @(posedge aclk) begin
        if (en2) begin
            last2_reg <= last1_reg;
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= PW'(lpg_pkg::div255(sq_reg[i])) * PW'(cfg.brightness);
            end
        end
    end

    // g*b/255 is exact for b = 0 and b = 255 too, so no special cases
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            comp[i] = lpg_pkg::div255(prod_reg[i]);
        end
        push_entry.word = {comp[lpg_pkg::order_sel(cfg.color_order, 2'd0)],
                           comp[lpg_pkg::order_sel(cfg.color_order, 2'd1)],
                           comp[lpg_pkg::order_sel(cfg.color_order, 2'd2)],
                           comp[3]};
        push_entry.last = last2_reg;
    end

endmodule

[hw/rtl/lpg_queue.sv]
// Small FIFO of pixel words between the front pipeline and the serializer.
module lpg_queue #(
    parameter int unsigned DEPTH = lpg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lpg_pkg::lpg_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output lpg_pkg::lpg_entry_t pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lpg_pkg::lpg_entry_t mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)) else $error("queue count over depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |-> !push) else $error("push into full queue");

endmodule

[hw/rtl/lpg_back.sv]
// Serializer: one bit symbol per cycle from queue words while the sink is ready, closing reset symbol, output register.
module lpg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpg_pkg::lpg_cfg_t   cfg,
    input  logic                q_not_empty,
    input  lpg_pkg::lpg_entry_t pop_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tlast
);

    localparam int unsigned IW = lpg_pkg::SYM_IDX_W;

    logic                       busy_reg;
    logic [lpg_pkg::WORD_W-1:0] word_reg;
    logic                       last_reg;
    logic [IW-1:0]              idx_reg;
    logic                       m_tvalid_reg, m_tlast_reg;
    logic [31:0]                m_tdata_reg;

    logic          emit, final_sym, is_reset_sym, bit_val;
    logic [IW-1:0] total;
    logic [lpg_pkg::TICK_W-1:0] hi_ticks, lo_ticks;

    always_comb begin
        total        = (cfg.has_white ? IW'(32) : IW'(24)) + IW'(last_reg);
        final_sym    = (idx_reg == total - 1'b1);
        is_reset_sym = idx_reg[5] | (idx_reg[4:3] == 2'd3 && !cfg.has_white);
        bit_val      = word_reg[~idx_reg[4:0]];
        emit         = busy_reg && (!m_tvalid_reg || m_tready);
        pop          = q_not_empty && (!busy_reg || (emit && final_sym));
        hi_ticks     = is_reset_sym ? cfg.latch_ticks : (bit_val ? cfg.one_high : cfg.zero_high);
        lo_ticks     = is_reset_sym ? cfg.latch_ticks : (bit_val ? cfg.one_low : cfg.zero_low);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (emit) begin
            busy_reg <= !final_sym;
            idx_reg  <= final_sym ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg <= pop_entry.word;
            last_reg <= pop_entry.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // {second_ticks, second_level, first_ticks, first_level}
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {lo_ticks, 1'b0, hi_ticks, !is_reset_sym};
            m_tlast_reg <= final_sym;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < total) else $error("symbol index past pixel end");
    a_idle_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> idx_reg == '0) else $error("idle serializer with stale index");

endmodule

[hw/rtl/led_pixel_gamma_ws2812_encoder_top.sv]
// Top level: config registers, front pipeline, pixel queue and symbol serializer.
// Path: stage 1 and stage 2 registers, queue, serializer word register, then the output register.
// Throughput: 24 symbols per pixel (32 with white), one more on a frame's last pixel;
//   the serializer sends one symbol per cycle while the sink is ready.
// The front pipeline takes a new word every cycle until the queue fills.
// Reset (synchronous, aresetn low): registers to defaults, pipeline, queue and output empty.
module led_pixel_gamma_ws2812_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], white[31:24]
    input  logic        s_tlast,   // last_pixel
    // symbol words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // first_level[0], first_ticks[15:1],
                                   // second_level[16], second_ticks[31:17]
    output logic        m_tlast,   // last_symbol
    // config writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata
);

    lpg_pkg::lpg_cfg_t   cfg_reg;
    lpg_pkg::lpg_entry_t push_entry, pop_entry;
    logic                push, pop, q_full, q_not_empty;
    logic [7:0]          in_comp [4];

    // Register file; the user must write it only while the block is idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.brightness  <= lpg_pkg::FULL_SCALE;
            cfg_reg.color_order <= lpg_pkg::ORD_GRB;
            cfg_reg.has_white   <= 1'b0;
            cfg_reg.zero_high   <= lpg_pkg::ZERO_HIGH_RST;
            cfg_reg.zero_low    <= lpg_pkg::ZERO_LOW_RST;
            cfg_reg.one_high    <= lpg_pkg::ONE_HIGH_RST;
            cfg_reg.one_low     <= lpg_pkg::ONE_LOW_RST;
            cfg_reg.latch_ticks <= lpg_pkg::LATCH_RST;
        end else if (cfg_we) begin
            case (lpg_pkg::lpg_reg_idx_t'(cfg_index))
                lpg_pkg::REG_BRIGHTNESS:  cfg_reg.brightness  <= cfg_wdata[7:0];
                lpg_pkg::REG_COLOR_ORDER: cfg_reg.color_order <= cfg_wdata[2:0];
                lpg_pkg::REG_HAS_WHITE:   cfg_reg.has_white   <= cfg_wdata[0];
                lpg_pkg::REG_ZERO_HIGH:   cfg_reg.zero_high   <= cfg_wdata;
                lpg_pkg::REG_ZERO_LOW:    cfg_reg.zero_low    <= cfg_wdata;
                lpg_pkg::REG_ONE_HIGH:    cfg_reg.one_high    <= cfg_wdata;
                lpg_pkg::REG_ONE_LOW:     cfg_reg.one_low     <= cfg_wdata;
                lpg_pkg::REG_LATCH_TICKS: cfg_reg.latch_ticks <= cfg_wdata;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // component 3 is white; it only reaches the line when has_white is set
    assign in_comp[0] = s_tdata[7:0];
    assign in_comp[1] = s_tdata[15:8];
    assign in_comp[2] = s_tdata[23:16];
    assign in_comp[3] = s_tdata[31:24];

    lpg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_comp    (in_comp),
        .in_last    (s_tlast),
        .push       (push),
        .q_full     (q_full),
        .push_entry (push_entry)
    );

    lpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .pop_entry  (pop_entry)
    );

    lpg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .pop_entry   (pop_entry),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

[tb/sv/led_pixel_gamma_ws2812_encoder_checker.sv]
// Checker for the LED pixel encoder: tracks registers, predicts symbol words, compares.
module led_pixel_gamma_ws2812_encoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        run_done,
    output int          pending,
    output int          fail_cnt
);

    typedef struct packed {
        logic                       first_level;
        logic [lpg_pkg::TICK_W-1:0] first_ticks;
        logic                       second_level;
        logic [lpg_pkg::TICK_W-1:0] second_ticks;
        logic                       last;
    } symbol_t;

    symbol_t symbol_q[$];
    int      errors     = 0;
    int      symbol_cnt = 0;
    bit      drained    = 1'b0;

    // shadow of the register file
    logic [lpg_pkg::COMP_W-1:0] bright;
    logic [2:0]                 order;
    logic                       with_white;
    logic [lpg_pkg::TICK_W-1:0] zero_hi, zero_lo, one_hi, one_lo, rst_ticks;

    assign pending  = symbol_q.size();
    assign fail_cnt = errors;

    task automatic report(input string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // gamma v*v/255, then brightness scaling
    function automatic logic [lpg_pkg::COMP_W-1:0] shade(input logic [lpg_pkg::COMP_W-1:0] v);
        logic [15:0] sq;
        logic [15:0] g;
        sq = 16'(v) * 16'(v);
        g  = sq / 16'd255;
        if (bright == 8'd0)
            return 8'd0;
        if (bright != 8'd255)
            return 8'((g * 16'(bright)) / 16'd255);
        return g[7:0];
    endfunction

    task automatic predict_pixel(input logic [31:0] data, input logic last_px);
        logic [7:0]  r, g, b, w;
        logic [23:0] line;
        logic [31:0] word;
        int          low_bit;
        int          i;
        symbol_t     sym;
        r = shade(data[7:0]);
        g = shade(data[15:8]);
        b = shade(data[23:16]);
        w = shade(data[31:24]);
        case (lpg_pkg::lpg_order_t'(order))
            lpg_pkg::ORD_RGB: line = {r, g, b};
            lpg_pkg::ORD_RBG: line = {r, b, g};
            lpg_pkg::ORD_GRB: line = {g, r, b};
            lpg_pkg::ORD_GBR: line = {g, b, r};
            lpg_pkg::ORD_BRG: line = {b, r, g};
            default:          line = {b, g, r};   // BGR and the two unused codes
        endcase
        word    = {line, w};
        low_bit = with_white ? 0 : 8;
        for (i = 31; i >= low_bit; i--) begin
            sym.first_level  = 1'b1;
            sym.first_ticks  = word[i] ? one_hi : zero_hi;
            sym.second_level = 1'b0;
            sym.second_ticks = word[i] ? one_lo : zero_lo;
            sym.last         = (i == low_bit) && !last_px;
            symbol_q.push_back(sym);
        end
        if (last_px) begin
            sym = '{1'b0, rst_ticks, 1'b0, rst_ticks, 1'b1};
            symbol_q.push_back(sym);
        end
    endtask

    task automatic check_symbol();
        symbol_t got;
        symbol_t want;
        got = '{m_tdata[0], m_tdata[15:1], m_tdata[16], m_tdata[31:17], m_tlast};
        symbol_cnt++;
        if (symbol_q.size() == 0) begin
            report($sformatf("symbol %0d arrived with nothing expected", symbol_cnt));
        end else begin
            want = symbol_q.pop_front();
            if (got !== want)
                report($sformatf({"symbol %0d: got %b/%0d %b/%0d last %b, ",
                                  "want %b/%0d %b/%0d last %b"}, symbol_cnt,
                                 got.first_level, got.first_ticks, got.second_level,
                                 got.second_ticks, got.last, want.first_level,
                                 want.first_ticks, want.second_level,
                                 want.second_ticks, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            bright     = lpg_pkg::FULL_SCALE;
            order      = lpg_pkg::ORD_GRB;
            with_white = 1'b0;
            zero_hi    = lpg_pkg::ZERO_HIGH_RST;
            zero_lo    = lpg_pkg::ZERO_LOW_RST;
            one_hi     = lpg_pkg::ONE_HIGH_RST;
            one_lo     = lpg_pkg::ONE_LOW_RST;
            rst_ticks  = lpg_pkg::LATCH_RST;
            symbol_q.delete();
        end else begin
            if (cfg_we) begin
                case (lpg_pkg::lpg_reg_idx_t'(cfg_index))
                    lpg_pkg::REG_BRIGHTNESS:  bright     = cfg_wdata[7:0];
                    lpg_pkg::REG_COLOR_ORDER: order      = cfg_wdata[2:0];
                    lpg_pkg::REG_HAS_WHITE:   with_white = cfg_wdata[0];
                    lpg_pkg::REG_ZERO_HIGH:   zero_hi    = cfg_wdata;
                    lpg_pkg::REG_ZERO_LOW:    zero_lo    = cfg_wdata;
                    lpg_pkg::REG_ONE_HIGH:    one_hi     = cfg_wdata;
                    lpg_pkg::REG_ONE_LOW:     one_lo     = cfg_wdata;
                    lpg_pkg::REG_LATCH_TICKS: rst_ticks  = cfg_wdata;
                    default:                  rst_ticks  = rst_ticks;
                endcase
            end
            if (m_tvalid && m_tready)
                check_symbol();
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata, s_tlast);
            if (run_done && !drained) begin
                drained = 1'b1;
                foreach (symbol_q[k])
                    report($sformatf("expected symbol %0d never arrived", k));
            end
        end
    end

endmodule

[tb/sv/led_pixel_gamma_ws2812_encoder_top_test.sv]
// Testbench top: clock, reset, pixel and register stimulus, watchdog and verdict.
module led_pixel_gamma_ws2812_encoder_top_test;

    localparam int IDLE_LIMIT = 2000;   // cycles with no word moving on any port
    localparam int RAND_PHASES = 5;
    localparam int RAND_ITEMS  = 56;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // red[7:0], green[15:8], blue[23:16], white[31:24]
    logic        s_tlast   = 1'b0;  // last_pixel
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // first_level[0], first_ticks[15:1],
                                    // second_level[16], second_ticks[31:17]
    logic        m_tlast;           // last_symbol
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [14:0] cfg_wdata = '0;
    logic        run_done  = 1'b0;
    bit          no_gaps   = 1'b0;  // one stretch of the run with no idling on either side
    int          pending;
    int          fail_cnt;
    int          idle_cycles = 0;

    // staged register values, indexed by register code
    logic [14:0] reg_val [0:7];

    always #10 aclk = ~aclk;

    led_pixel_gamma_ws2812_encoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    led_pixel_gamma_ws2812_encoder_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .run_done  (run_done),
        .pending   (pending),
        .fail_cnt  (fail_cnt)
    );

    // Symbol sink: back-pressure about 28% of cycles, none during the steady stretch.
    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 28);
    end

    // Watchdog: give up if nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[led_pixel_gamma_ws2812_encoder_top] ERROR");
                $finish;
            end
        end
    end

    // One pixel word. Random idle cycles ahead of it; valid stays high into the next
    // word when there is no gap, so it is never dropped and raised in one step.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] w, input logic last_px);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 28) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, b, g, r};
        s_tlast  <= last_px;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every predicted symbol has come out. Every pixel
    // yields symbols, so an empty expectation list means the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Write all eight registers back to back, only while the block is idle.
    task automatic set_config(input logic [7:0] bright, input logic [2:0] order,
                              input logic white, input logic [14:0] zh,
                              input logic [14:0] zl, input logic [14:0] oh,
                              input logic [14:0] ol, input logic [14:0] rst);
        lpg_pkg::lpg_reg_idx_t r;
        reg_val[lpg_pkg::REG_BRIGHTNESS]  = {7'd0, bright};
        reg_val[lpg_pkg::REG_COLOR_ORDER] = {12'd0, order};
        reg_val[lpg_pkg::REG_HAS_WHITE]   = {14'd0, white};
        reg_val[lpg_pkg::REG_ZERO_HIGH]   = zh;
        reg_val[lpg_pkg::REG_ZERO_LOW]    = zl;
        reg_val[lpg_pkg::REG_ONE_HIGH]    = oh;
        reg_val[lpg_pkg::REG_ONE_LOW]     = ol;
        reg_val[lpg_pkg::REG_LATCH_TICKS] = rst;
        r = r.first();
        repeat (8) begin
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_wdata <= reg_val[r];
            @(posedge aclk);
            r = r.next();
        end
        cfg_we <= 1'b0;
    endtask

    // Components lean toward the extremes now and then.
    function automatic logic [7:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly short symbols, sometimes the widest, sometimes anything.
    function automatic logic [14:0] rand_ticks();
        case ($urandom_range(0, 7))
            0:       return 15'd32767;
            1:       return 15'($urandom_range(1, 32767));
            default: return 15'($urandom_range(1, 20));
        endcase
    endfunction

    task automatic random_config();
        logic [7:0] bright;
        case ($urandom_range(0, 3))
            0:       bright = 8'd0;
            1:       bright = 8'd255;
            default: bright = 8'($urandom_range(0, 255));
        endcase
        set_config(bright, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
    endtask

    initial begin
        int ph;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: GRB, no white, full brightness
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255, 1'b1);   // white ignored here
        send_pixel(8'd16,  8'd128, 8'd200, 8'd77,  1'b0);
        send_pixel(8'd1,   8'd254, 8'd15,  8'd240, 1'b1);
        drain();

        // blanked, RGB, white on, shortest ticks
        set_config(8'd0, lpg_pkg::ORD_RGB, 1'b1, 15'd1, 15'd1, 15'd1, 15'd1, 15'd1);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd64,  8'd32,  8'd16,  1'b1);
        drain();

        // dimmest nonzero brightness, RBG, longest ticks
        set_config(8'd1, lpg_pkg::ORD_RBG, 1'b1, 15'd32767, 15'd32767, 15'd32767,
                   15'd32767, 15'd32767);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd200, 8'd100, 8'd50,  8'd25,  1'b0);
        drain();

        // registers holding zero go out as zero ticks
        set_config(8'd254, lpg_pkg::ORD_GBR, 1'b0, 15'd0, 15'd0, 15'd5, 15'd0, 15'd0);
        send_pixel(8'd255, 8'd0,   8'd128, 8'd9,   1'b1);
        send_pixel(8'd3,   8'd250, 8'd60,  8'd0,   1'b0);
        drain();

        // unused order codes fall back to BGR
        set_config(8'd128, 3'd6, 1'b1, 15'd2, 15'd7, 15'd6, 15'd3, 15'd40);
        send_pixel(8'd255, 8'd128, 8'd1,   8'd200, 1'b0);
        send_pixel(8'd10,  8'd20,  8'd30,  8'd40,  1'b1);
        drain();
        set_config(8'd200, 3'd7, 1'b0, 15'd4, 15'd8, 15'd8, 15'd4, 15'd50);
        send_pixel(8'd90,  8'd180, 8'd45,  8'd255, 1'b1);
        drain();

        set_config(8'd170, lpg_pkg::ORD_BRG, 1'b0, 15'd3, 15'd9, 15'd9, 15'd3, 15'd100);
        send_pixel(8'd255, 8'd100, 8'd0,   8'd7,   1'b0);
        drain();
        set_config(8'd255, lpg_pkg::ORD_BGR, 1'b1, 15'd3, 15'd9, 15'd9, 15'd3, 15'd1);
        send_pixel(8'd255, 8'd100, 8'd0,   8'd77,  1'b1);
        drain();

        // random frames under random settings; one phase runs without idling
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            random_config();
            no_gaps = (ph == 2);
            repeat (RAND_ITEMS)
                send_pixel(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                           $urandom_range(0, 7) == 0);
            drain();
        end
        no_gaps = 1'b0;

        // let any stray symbol show up before the leftover check
        repeat (10) @(posedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_cnt == 0)
            $display("[led_pixel_gamma_ws2812_encoder_top] OK");
        else
            $display("[led_pixel_gamma_ws2812_encoder_top] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_front.sv
hw/rtl/lpg_queue.sv
hw/rtl/lpg_back.sv
hw/rtl/led_pixel_gamma_ws2812_encoder_top.sv
tb/sv/led_pixel_gamma_ws2812_encoder_checker.sv
tb/sv/led_pixel_gamma_ws2812_encoder_top_test.sv
